### hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: shared constants and a helper for modular exponentiation
// Operand width, field width, bit counter width and the conditional
// subtract used by the bit-serial reduction and multiplication units.
// ----------------------------------------------------------------------------
package mexp_pkg;

	// Operand width used by the arithmetic (8..64)
	localparam int WIDTH   = 64;
	// Width of the field ports
	localparam int FIELD_W = 64;
	// Bit counter width for a WIDTH-step scan
	localparam int BIT_W   = $clog2(WIDTH);

	typedef logic [WIDTH-1:0] word_t;
	typedef logic [WIDTH:0]   wide_t;

	// Reduce x once by m, valid where x < 2m
	function automatic word_t sub_if_ge(input wide_t x, input word_t m);
		wide_t mx;
		wide_t d;
		mx = {1'b0, m};
		d  = x - mx;
		return (x >= mx) ? d[WIDTH-1:0] : x[WIDTH-1:0];
	endfunction

endpackage

### hw/rtl/mexp_reduce.sv
// ----------------------------------------------------------------------------
// mexp_reduce: bit-serial remainder
// Shifts the dividend in MSB first, one bit per cycle, keeping a partial
// remainder below the modulus.
// ----------------------------------------------------------------------------
module mexp_reduce import mexp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t value,
	input  word_t m,
	output logic  done,
	output word_t rem
);

	logic             busy_q;
	logic             done_q;
	logic [BIT_W-1:0] cnt_q;
	word_t            val_q;
	word_t            rem_q;
	word_t            rem_next;

	// Bring in the next dividend bit and subtract once
	assign rem_next = sub_if_ge({rem_q, val_q[WIDTH-1]}, m);

	// Control: count WIDTH steps, raise done with the result of the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BIT_W'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shift register and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### hw/rtl/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul: bit-serial modular multiplier
// Computes (a * b) mod m by double-and-add over the bits of b, MSB first,
// one bit per cycle. a and m must hold steady while the unit runs.
// ----------------------------------------------------------------------------
module mexp_modmul import mexp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t a,
	input  word_t b,
	input  word_t m,
	output logic  done,
	output word_t product
);

	logic             busy_q;
	logic             done_q;
	logic [BIT_W-1:0] cnt_q;
	word_t            b_q;
	word_t            acc_q;
	word_t            dbl;
	word_t            acc_next;

	// Double the accumulator, then add a when the current bit is set
	always_comb begin
		dbl = sub_if_ge({acc_q, 1'b0}, m);
		if (b_q[WIDTH-1]) begin
			acc_next = sub_if_ge({1'b0, dbl} + {1'b0, a}, m);
		end else begin
			acc_next = dbl;
		end
	end

	// Control: count WIDTH steps, raise done with the result of the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BIT_W'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: multiplier shift register and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= {b_q[WIDTH-2:0], 1'b0};
			acc_q <= acc_next;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

### hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: base ** exponent mod modulus
// Right-to-left square and multiply built on bit-serial arithmetic units.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries base_value, exponent, modulus.
//   Output channel (out_valid/out_ready) carries power_result, modulus_error.
//   One item is worked on at a time; in_ready is high only while idle.
//   A zero modulus returns modulus_error = 1 and power_result = 0.
//   A zero exponent returns 1 (unreduced).
//   Otherwise the base is first reduced by a bit-serial remainder unit,
//   then each exponent bit up to the highest set one takes a round in
//   which the square and the conditional multiply run in parallel on
//   two bit-serial multipliers, one operand bit per cycle.
//   The result sits in an output register; a new transaction is accepted
//   while it waits. A second result stalls until the first is taken.
//   Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module modular_exponentiation import mexp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FIELD_W-1:0] base_value,
	input  logic [FIELD_W-1:0] exponent,
	input  logic [FIELD_W-1:0] modulus,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [FIELD_W-1:0] power_result,
	output logic               modulus_error
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_REDUCE = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_MUL    = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;
	word_t      b_q;
	word_t      e_q;
	word_t      m_q;
	word_t      r_q;
	logic       err_q;
	logic       out_valid_q;
	word_t      out_r_q;
	logic       out_err_q;

	logic       accept;
	logic       red_start;
	logic       red_done;
	word_t      red_rem;
	logic       mul_start;
	logic       mul1_done;
	logic       mul2_done;
	word_t      mul1_prod;
	word_t      mul2_prod;
	word_t      r_op;
	logic       out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign red_start = accept && (modulus[WIDTH-1:0] != '0);
	assign mul_start = (state_q == S_CHECK) && (e_q != '0);
	assign out_load  = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	// Running result reduced once: only 1 mod 1 needs it
	assign r_op = (m_q == word_t'(1)) ? '0 : r_q;

	mexp_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.value  (base_value[WIDTH-1:0]),
		.m      (m_q),
		.done   (red_done),
		.rem    (red_rem)
	);

	// Multiply the running result by the base
	mexp_modmul u_mul_res (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (r_op),
		.b       (b_q),
		.m       (m_q),
		.done    (mul1_done),
		.product (mul1_prod)
	);

	// Square the base
	mexp_modmul u_mul_sq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (b_q),
		.b       (b_q),
		.m       (m_q),
		.done    (mul2_done),
		.product (mul2_prod)
	);

	// Sequence: reduce, then a square/multiply round per bit until e_q is zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (modulus[WIDTH-1:0] == '0) ? S_FINISH : S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (red_done) state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= (e_q == '0) ? S_FINISH : S_MUL;
				end
				S_MUL: begin
					if (mul1_done) state_q <= S_CHECK;
				end
				S_FINISH: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold operands and the running result
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q   <= exponent[WIDTH-1:0];
			m_q   <= modulus[WIDTH-1:0];
			r_q   <= '0;
			err_q <= (modulus[WIDTH-1:0] == '0);
		end else if ((state_q == S_REDUCE) && red_done) begin
			b_q <= red_rem;
			r_q <= word_t'(1);
		end else if ((state_q == S_MUL) && mul1_done) begin
			if (e_q[0]) r_q <= mul1_prod;
			b_q <= mul2_prod;
			e_q <= {1'b0, e_q[WIDTH-1:1]};
		end
	end

	// Output register: load when free or being drained, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_r_q   <= r_q;
			out_err_q <= err_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign power_result  = FIELD_W'(out_r_q);
	assign modulus_error = out_err_q;

	// Both multipliers run in lockstep
	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mul1_done == mul2_done)
		else $error("multiplier units out of step");

	// The base stays reduced while exponent bits are processed
	a_base_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK || state_q == S_MUL) |-> (b_q < m_q))
		else $error("base not reduced below modulus");

	// An error result carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && modulus_error) |-> (power_result == '0))
		else $error("error result with nonzero value");

	// Remainder unit finishes only while the sequencer waits for it
	a_red_done: assert property (@(posedge clk) disable iff (!arst_n)
		red_done |-> (state_q == S_REDUCE))
		else $error("unexpected remainder completion");

endmodule
